// ===== design/erd_pkg.sv =====
// Shared types, codes and constants for the echo range display.
`default_nettype none

package erd_pkg;

   // Operation codes of an input item; code 3 is unused and ignored
   typedef enum logic [1:0] {
      OP_REFRESH = 2'd0,
      OP_CAPTURE = 2'd1,
      OP_CLEAR   = 2'd2
   } erd_op_type;

   localparam int unsigned OP_W       = 2;
   localparam int unsigned WIDTH_W    = 16;
   localparam int unsigned SEG_W      = 8;
   localparam int unsigned DIGITS     = 4;
   localparam int unsigned POS_W      = 2;
   localparam int unsigned DIST_W     = 10;

   // Echo conversion: (w + 58) / 116 = ((w + 58) >> 2) / 29
   localparam logic [WIDTH_W:0] ECHO_ROUND  = 17'd58;
   localparam logic [14:0]      RECIP_29    = 15'd18079;  // ceil(2^19 / 29)
   localparam int unsigned      RECIP_SHIFT = 19;

   // Decimal split of a 10-bit value
   localparam logic [9:0] RECIP_10  = 10'd820;   // ceil(2^13 / 10)
   localparam logic [9:0] RECIP_100 = 10'd656;   // ceil(2^16 / 100)
   localparam logic [DIST_W-1:0] THOUSAND = 10'd1000;
   localparam logic [DIST_W-1:0] HUNDRED  = 10'd100;
   localparam logic [DIST_W-1:0] TEN      = 10'd10;

   localparam logic [1:0] POS_THOUSANDS = 2'd0;
   localparam logic [1:0] POS_HUNDREDS  = 2'd1;
   localparam logic [1:0] POS_TENS      = 2'd2;
   localparam logic [1:0] POS_UNITS     = 2'd3;

   localparam logic [SEG_W-1:0]  SEG_ALL_OFF = 8'hff;
   localparam logic [DIGITS-1:0] EN_ALL_OFF  = 4'hf;

   // What one refresh tick puts on the display
   typedef struct packed {
      logic              shown;
      logic [SEG_W-1:0]  segments_n;
      logic [DIGITS-1:0] enable_n;
   } erd_disp_type;

   // Active-low segment pattern of a decimal digit, bits B,F,A,E,D,DP,C,G
   function automatic logic [SEG_W-1:0] seg_lookup(input logic [3:0] digit);
      logic [SEG_W-1:0] pattern;
      case (digit)
         4'd0:    pattern = 8'ha0;
         4'd1:    pattern = 8'hbe;
         4'd2:    pattern = 8'h62;
         4'd3:    pattern = 8'h2a;
         4'd4:    pattern = 8'h3c;
         4'd5:    pattern = 8'h29;
         4'd6:    pattern = 8'h21;
         4'd7:    pattern = 8'hba;
         4'd8:    pattern = 8'h20;
         4'd9:    pattern = 8'h28;
         default: pattern = SEG_ALL_OFF;
      endcase
      return pattern;
   endfunction

endpackage

`default_nettype wire

// ===== design/erd_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
`default_nettype none

interface erd_req_if;
   logic                         valid;
   logic                         ready;
   logic [erd_pkg::OP_W-1:0]     operation;
   logic [erd_pkg::WIDTH_W-1:0]  echo_width;

   modport source (output valid, output operation, output echo_width, input ready);
   modport sink   (input valid, input operation, input echo_width, output ready);
endinterface

interface erd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [erd_pkg::SEG_W-1:0]    segments_n;
   logic [erd_pkg::DIGITS-1:0]   digit_enable_n;
   logic [erd_pkg::DIST_W-1:0]   distance_cm;

   modport source (output valid, output segments_n, output digit_enable_n,
                   output distance_cm, input ready);
   modport sink   (input valid, input segments_n, input digit_enable_n,
                   input distance_cm, output ready);
endinterface

`default_nettype wire

// ===== design/erd_conv.sv =====
// Echo width to rounded centimetre distance, by reciprocal multiplication.
`default_nettype none

module erd_conv (
   input  wire logic [erd_pkg::WIDTH_W-1:0] echo_width,
   output logic      [erd_pkg::DIST_W-1:0]  distance
);
   import erd_pkg::*;

   logic [WIDTH_W:0] rounded;
   logic [14:0]      quarter;
   logic [29:0]      product;

   always_comb begin
      rounded = {1'b0, echo_width} + ECHO_ROUND;
      // divide by 4 first, then by 29 through the reciprocal
      quarter = rounded[WIDTH_W:2];
      product = 30'(quarter) * 30'(RECIP_29);
      distance = product[RECIP_SHIFT +: DIST_W];
   end

endmodule

`default_nettype wire

// ===== design/erd_digit.sv =====
// Digit selection, blanking and segment lookup for one refresh position.
`default_nettype none

module erd_digit (
   input  wire logic [erd_pkg::DIST_W-1:0] distance,
   input  wire logic [erd_pkg::POS_W-1:0]  position,
   output erd_pkg::erd_disp_type           disp
);
   import erd_pkg::*;

   logic [19:0]       prod_10;
   logic [19:0]       prod_100;
   logic [6:0]        div_10;
   logic [3:0]        div_100;
   logic [9:0]        times_10;
   logic [6:0]        hund_times_10;
   logic [9:0]        units_full;
   logic [6:0]        tens_full;
   logic [3:0]        digit;
   logic              nonzero;

   always_comb begin
      prod_10  = 20'(distance) * 20'(RECIP_10);
      prod_100 = 20'(distance) * 20'(RECIP_100);
      div_10   = prod_10[19:13];
      div_100  = prod_100[19:16];

      times_10      = {div_10, 3'b000} + {2'b00, div_10, 1'b0};
      hund_times_10 = {div_100, 3'b000} + {2'b00, div_100, 1'b0};
      units_full    = distance - times_10;
      tens_full     = div_10 - hund_times_10;

      case (position)
         POS_THOUSANDS: begin
            nonzero = (distance >= THOUSAND);
            digit   = {3'b000, nonzero};
         end
         POS_HUNDREDS: begin
            nonzero = (distance >= HUNDRED);
            // a quotient of ten shows its last digit, zero
            digit   = (div_100 == 4'd10) ? 4'd0 : div_100;
         end
         POS_TENS: begin
            nonzero = (distance >= TEN);
            digit   = tens_full[3:0];
         end
         default: begin
            nonzero = 1'b1;
            digit   = units_full[3:0];
         end
      endcase

      disp.shown      = nonzero;
      disp.segments_n = seg_lookup(digit);
      disp.enable_n   = ~(DIGITS'(1) << position);
   end

endmodule

`default_nettype wire

// ===== design/echo_range_seven_segment_display.sv =====
// Top level of the echo range display: input stage, state and response register.
//
//  Channel   Dir  Payload                                      Transfer
//  req_ch    in   operation[2], echo_width[16]                 valid & ready
//  rsp_ch    out  segments_n[8], digit_enable_n[4],            valid & ready
//                 distance_cm[10]
//
// One item per cycle while the response side is not stalled. An item is held in the
// input register, then passes through the conversion or digit logic into the
// response register, which raises response valid.
// Synchronous reset clears the distance and digit position, turns all segments and
// digits off and empties both stages. A stalled response holds its register while
// the input stage still takes one more item; state updates only as an item moves on.
`default_nettype none

module echo_range_seven_segment_display (
   input  wire logic   clock,
   input  wire logic   reset,
   erd_req_if.sink     req_ch,
   erd_rsp_if.source   rsp_ch
);
   import erd_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [OP_W-1:0]      in_op_ff;
   logic [WIDTH_W-1:0]   in_width_ff;

   logic [DIST_W-1:0]    distance_ff, distance_in;
   logic [POS_W-1:0]     position_ff, position_in;
   logic [SEG_W-1:0]     seg_latch_ff, seg_latch_in;
   logic [DIGITS-1:0]    en_latch_ff, en_latch_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SEG_W-1:0]     rsp_seg_ff;
   logic [DIGITS-1:0]    rsp_en_ff;
   logic [DIST_W-1:0]    rsp_dist_ff;

   logic                 advance;
   logic                 take;
   logic [DIST_W-1:0]    captured;
   erd_disp_type         disp;

   erd_conv u_conv (
      .echo_width (in_width_ff),
      .distance   (captured)
   );

   erd_digit u_digit (
      .distance (distance_ff),
      .position (position_ff),
      .disp     (disp)
   );

   always_comb begin
      advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
      req_ch.ready = !in_valid_ff || advance;
      take         = req_ch.valid && req_ch.ready;
      in_valid_in  = take || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);
   end

   // next state of the display and distance
   always_comb begin
      distance_in  = distance_ff;
      position_in  = position_ff;
      seg_latch_in = seg_latch_ff;
      en_latch_in  = en_latch_ff;
      case (erd_op_type'(in_op_ff))
         OP_REFRESH: begin
            position_in = position_ff + POS_W'(1);
            en_latch_in = EN_ALL_OFF;
            if (disp.shown) begin
               seg_latch_in = disp.segments_n;
               en_latch_in  = disp.enable_n;
            end
         end
         OP_CAPTURE: distance_in = captured;
         OP_CLEAR:   distance_in = '0;
         default:    ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         distance_ff  <= '0;
         position_ff  <= '0;
         seg_latch_ff <= SEG_ALL_OFF;
         en_latch_ff  <= EN_ALL_OFF;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            distance_ff  <= distance_in;
            position_ff  <= position_in;
            seg_latch_ff <= seg_latch_in;
            en_latch_ff  <= en_latch_in;
         end
      end
   end

   // payload registers: load on transfer or advance, hold otherwise
   always_ff @(posedge clock) begin
      if (take) begin
         in_op_ff    <= req_ch.operation;
         in_width_ff <= req_ch.echo_width;
      end
      if (advance) begin
         rsp_seg_ff  <= seg_latch_in;
         rsp_en_ff   <= en_latch_in;
         rsp_dist_ff <= distance_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.segments_n     = rsp_seg_ff;
   assign rsp_ch.digit_enable_n = rsp_en_ff;
   assign rsp_ch.distance_cm    = rsp_dist_ff;

endmodule

`default_nettype wire
